// ----- rtl/zbuffered_triangle_raster_defines.svh -----
// Assertion macros for the z-buffered triangle rasterizer.
`ifndef ZBUFFERED_TRIANGLE_RASTER_DEFINES_SVH
`define ZBUFFERED_TRIANGLE_RASTER_DEFINES_SVH
`ifndef SYNTH
`define ZBR_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("zbr assertion failed");
`define ZBR_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
        else $error("zbr forbidden condition");
`else
`define ZBR_ASSERT(label, clk, rstn, prop)
`define ZBR_NEVER(label, clk, rstn, expr)
`endif
`endif

// ----- rtl/zbr_pkg.sv -----
// Shared types and constants for the z-buffered triangle rasterizer.
package zbr_pkg;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_STEP = 1'b1;
    localparam logic signed [15:0] DEPTH_MIN = 16'sh8000;
    localparam int DIV_STEPS = 16;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SETUP_BOX,
        ST_SETUP_AREA,
        ST_EDGE_MUL,
        ST_EDGE_TEST,
        ST_DEPTH_MUL,
        ST_DEPTH_SUM,
        ST_DIV,
        ST_FINISH
    } zbr_state_t;

    typedef struct packed {
        logic clear_wr;
        logic load;
        logic setup_box;
        logic setup_area;
        logic edge_mul;
        logic edge_test;
        logic depth_mul;
        logic depth_sum;
        logic div_step;
        logic finish;
    } zbr_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic scan_active;
        logic covered;
        logic div_done;
        logic out_free;
    } zbr_status_t;

endpackage

// ----- rtl/zbr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module zbr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

// ----- rtl/zbr_ctrl.sv -----
// Sequencer for setup, per-pixel evaluation and depth-store clearing.
module zbr_ctrl
    import zbr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  zbr_status_t status,
    output zbr_cmd_t    cmd
);
    zbr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_func == FUNC_LOAD) begin
                        cmd.load   = 1'b1;
                        state_next = ST_SETUP_BOX;
                    end else if (status.scan_active) begin
                        state_next = ST_EDGE_MUL;
                    end
                end
            end
            ST_SETUP_BOX: begin
                cmd.setup_box = 1'b1;
                state_next    = ST_SETUP_AREA;
            end
            ST_SETUP_AREA: begin
                cmd.setup_area = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_EDGE_MUL: begin
                cmd.edge_mul = 1'b1;
                state_next   = ST_EDGE_TEST;
            end
            ST_EDGE_TEST: begin
                cmd.edge_test = 1'b1;
                state_next    = ST_DEPTH_MUL;
            end
            ST_DEPTH_MUL: begin
                // uncovered pixels skip the depth path
                if (status.covered) begin
                    cmd.depth_mul = 1'b1;
                    state_next    = ST_DEPTH_SUM;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_DEPTH_SUM: begin
                cmd.depth_sum = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                if (status.div_done) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

// ----- rtl/zbr_datapath.sv -----
// Vertex registers, edge and depth arithmetic, divider, depth store, result register.
`include "zbuffered_triangle_raster_defines.svh"
module zbr_datapath
    import zbr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  zbr_cmd_t           cmd,
    output zbr_status_t        status,
    input  logic signed [11:0] s_ax,
    input  logic signed [11:0] s_ay,
    input  logic signed [15:0] s_az,
    input  logic signed [11:0] s_bx,
    input  logic signed [11:0] s_by,
    input  logic signed [15:0] s_bz,
    input  logic signed [11:0] s_cx,
    input  logic signed [11:0] s_cy,
    input  logic signed [15:0] s_cz,
    input  logic [23:0]        s_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pixel_x,
    output logic [7:0]         m_pixel_y,
    output logic               m_written,
    output logic [23:0]        m_pixel_color,
    output logic signed [15:0] m_pixel_depth,
    output logic               m_last
);
    localparam int XW    = $clog2(SCREEN_WIDTH);
    localparam int YW    = $clog2(SCREEN_HEIGHT);
    localparam int DEPTH = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic signed [12:0] XMAX = 13'(SCREEN_WIDTH - 1);
    localparam logic signed [12:0] YMAX = 13'(SCREEN_HEIGHT - 1);

    // vertex and triangle state
    logic signed [11:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;
    logic signed [15:0] az_reg, bz_reg, cz_reg;
    logic [23:0]        color_reg;
    logic [XW-1:0]      xmin_reg, xmax_reg, x_reg;
    logic [YW-1:0]      ymin_reg, ymax_reg, y_reg;
    logic signed [25:0] ap0_reg, ap1_reg;
    logic signed [26:0] area_reg;
    logic               active_reg;

    // per-pixel pipeline
    logic signed [25:0] e0_reg, e1_reg, e2_reg, e3_reg;
    logic signed [26:0] ux_reg, uy_reg;
    logic [26:0]        uz_reg;
    logic               covered_reg;
    logic signed [43:0] m0_reg, m1_reg, m2_reg;
    logic               neg_reg;
    logic [26:0]        rem_reg;
    logic [15:0]        quo_reg;
    logic [3:0]         div_cnt_reg;
    logic [AW-1:0]      clr_cnt_reg;

    // result register
    logic               m_valid_reg;
    logic [7:0]         out_x_reg, out_y_reg;
    logic               out_written_reg, out_last_reg;
    logic [23:0]        out_color_reg;
    logic signed [15:0] out_depth_reg;

    function automatic logic signed [11:0] min3(input logic signed [11:0] a,
                                                input logic signed [11:0] b,
                                                input logic signed [11:0] c);
        logic signed [11:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [11:0] max3(input logic signed [11:0] a,
                                                input logic signed [11:0] b,
                                                input logic signed [11:0] c);
        logic signed [11:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [12:0] clamp(input logic signed [11:0] v,
                                          input logic signed [12:0] hi);
        logic signed [12:0] w;
        w = 13'(v);
        if (w < 0) begin
            return '0;
        end else if (w > hi) begin
            return hi;
        end
        return w;
    endfunction

    // combinational helpers
    logic signed [12:0] px_s, py_s, dax, day, dbx, dby, dcx, dcy, apx, apy;
    logic signed [26:0] ux_raw, uy_raw, ux_n, uy_n;
    logic signed [27:0] uxy_sum, w0;
    logic signed [45:0] num;
    logic [45:0]        num_abs;
    logic [27:0]        trial;
    logic               trial_ge;
    logic signed [15:0] depth_q;
    logic [15:0]        ram_rdata;
    logic               written_c, last_c;
    logic [AW-1:0]      pix_addr;

    assign px_s = 13'(x_reg);
    assign py_s = 13'(y_reg);
    assign dbx  = 13'(bx_reg) - 13'(ax_reg);
    assign dby  = 13'(by_reg) - 13'(ay_reg);
    assign dcx  = 13'(cx_reg) - 13'(ax_reg);
    assign dcy  = 13'(cy_reg) - 13'(ay_reg);
    assign dax  = 13'(ax_reg) - px_s;
    assign day  = 13'(ay_reg) - py_s;
    assign apx  = dax;
    assign apy  = day;

    assign ux_raw  = 27'(e0_reg) - 27'(e1_reg);
    assign uy_raw  = 27'(e2_reg) - 27'(e3_reg);
    assign ux_n    = area_reg[26] ? -ux_raw : ux_raw;
    assign uy_n    = area_reg[26] ? -uy_raw : uy_raw;
    assign uxy_sum = 28'(ux_n) + 28'(uy_n);
    assign w0      = $signed({1'b0, uz_reg}) - 28'(ux_reg) - 28'(uy_reg);

    assign num     = 46'(m0_reg) + 46'(m1_reg) + 46'(m2_reg);
    assign num_abs = num[45] ? 46'(-num) : 46'(num);

    assign trial    = {rem_reg, quo_reg[15]};
    assign trial_ge = trial >= {1'b0, uz_reg};
    assign depth_q  = neg_reg ? -$signed(quo_reg) : $signed(quo_reg);

    assign pix_addr = AW'(y_reg) * AW'(SCREEN_WIDTH) + AW'(x_reg);

    assign written_c = covered_reg && (depth_q > $signed(ram_rdata));
    assign last_c    = (y_reg >= ymax_reg) && (x_reg >= xmax_reg);

    zbr_ram #(
        .WIDTH(16),
        .DEPTH(DEPTH)
    ) u_depth_ram (
        .aclk (aclk),
        .we   (cmd.clear_wr || (cmd.finish && written_c)),
        .waddr(cmd.clear_wr ? clr_cnt_reg : pix_addr),
        .wdata(cmd.clear_wr ? DEPTH_MIN : depth_q),
        .re   (cmd.edge_test),
        .raddr(pix_addr),
        .rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            clr_cnt_reg <= '0;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear_wr) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.setup_area) begin
                active_reg <= 1'b1;
            end else if (cmd.finish && last_c) begin
                active_reg <= 1'b0;
            end
            if (cmd.depth_sum) begin
                div_cnt_reg <= '0;
            end else if (cmd.div_step) begin
                div_cnt_reg <= div_cnt_reg + 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ax_reg    <= s_ax;
            ay_reg    <= s_ay;
            az_reg    <= s_az;
            bx_reg    <= s_bx;
            by_reg    <= s_by;
            bz_reg    <= s_bz;
            cx_reg    <= s_cx;
            cy_reg    <= s_cy;
            cz_reg    <= s_cz;
            color_reg <= s_color;
        end
        if (cmd.setup_box) begin
            xmin_reg <= XW'(clamp(min3(ax_reg, bx_reg, cx_reg), XMAX));
            xmax_reg <= XW'(clamp(max3(ax_reg, bx_reg, cx_reg), XMAX));
            ymin_reg <= YW'(clamp(min3(ay_reg, by_reg, cy_reg), YMAX));
            ymax_reg <= YW'(clamp(max3(ay_reg, by_reg, cy_reg), YMAX));
            x_reg    <= XW'(clamp(min3(ax_reg, bx_reg, cx_reg), XMAX));
            y_reg    <= YW'(clamp(min3(ay_reg, by_reg, cy_reg), YMAX));
            ap0_reg  <= dcx * dby;
            ap1_reg  <= dbx * dcy;
        end
        if (cmd.setup_area) begin
            area_reg <= 27'(ap0_reg) - 27'(ap1_reg);
        end
        if (cmd.edge_mul) begin
            e0_reg <= dbx * apy;
            e1_reg <= apx * dby;
            e2_reg <= apx * dcy;
            e3_reg <= dcx * apy;
        end
        if (cmd.edge_test) begin
            ux_reg      <= ux_n;
            uy_reg      <= uy_n;
            uz_reg      <= area_reg[26] ? 27'(-area_reg) : 27'(area_reg);
            covered_reg <= (area_reg != 0) && !ux_n[26] && !uy_n[26]
                           && (uxy_sum <= (area_reg[26] ? 28'(-area_reg)
                                                        : 28'(area_reg)));
        end
        if (cmd.depth_mul) begin
            m0_reg <= az_reg * w0;
            m1_reg <= bz_reg * 28'(uy_reg);
            m2_reg <= cz_reg * 28'(ux_reg);
        end
        if (cmd.depth_sum) begin
            neg_reg <= num[45];
            rem_reg <= 27'(num_abs >> 16);
            quo_reg <= num_abs[15:0];
        end else if (cmd.div_step) begin
            rem_reg <= trial_ge ? 27'(trial - {1'b0, uz_reg}) : 27'(trial);
            quo_reg <= {quo_reg[14:0], trial_ge};
        end
        if (cmd.finish) begin
            out_x_reg       <= 8'(x_reg);
            out_y_reg       <= 8'(y_reg);
            out_written_reg <= written_c;
            out_color_reg   <= written_c ? color_reg : '0;
            out_depth_reg   <= covered_reg ? depth_q : '0;
            out_last_reg    <= last_c;
            if (y_reg >= ymax_reg) begin
                y_reg <= ymin_reg;
                if (x_reg < xmax_reg) begin
                    x_reg <= x_reg + 1'b1;
                end
            end else begin
                y_reg <= y_reg + 1'b1;
            end
        end
    end

    assign status.clear_done  = (clr_cnt_reg == AW'(DEPTH - 1));
    assign status.scan_active = active_reg;
    assign status.covered     = covered_reg;
    assign status.div_done    = (div_cnt_reg == 4'(DIV_STEPS - 1));
    assign status.out_free    = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_pixel_x     = out_x_reg;
    assign m_pixel_y     = out_y_reg;
    assign m_written     = out_written_reg;
    assign m_pixel_color = out_color_reg;
    assign m_pixel_depth = out_depth_reg;
    assign m_last        = out_last_reg;

    `ZBR_NEVER(a_clear_vs_finish, aclk, aresetn, cmd.clear_wr && cmd.finish)
    `ZBR_ASSERT(a_written_covered, aclk, aresetn, (cmd.finish && written_c) |-> covered_reg)
    `ZBR_ASSERT(a_scan_in_box, aclk, aresetn, active_reg |-> (x_reg >= xmin_reg && x_reg <= xmax_reg && y_reg >= ymin_reg && y_reg <= ymax_reg))
endmodule

// ----- rtl/zbuffered_triangle_raster.sv -----
// Top level of the z-buffered triangle rasterizer.
// After reset the depth store is cleared one entry per cycle, all SCREEN_WIDTH*SCREEN_HEIGHT
// entries (65536 by default); no item is taken during that pass.
// Load transfer: capture, then bounding box and area products, then area.
// Step transfer: an uncovered pixel skips the depth path; a covered one goes through the
// 16-step restoring divider on the interpolated depth; one item is in flight at a time.
// Reset is synchronous active-low aresetn; it clears control state and starts the clear.
module zbuffered_triangle_raster
    import zbr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_func,
    input  logic signed [11:0] s_ax,
    input  logic signed [11:0] s_ay,
    input  logic signed [15:0] s_az,
    input  logic signed [11:0] s_bx,
    input  logic signed [11:0] s_by,
    input  logic signed [15:0] s_bz,
    input  logic signed [11:0] s_cx,
    input  logic signed [11:0] s_cy,
    input  logic signed [15:0] s_cz,
    input  logic [23:0]        s_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_pixel_x,
    output logic [7:0]         m_pixel_y,
    output logic               m_written,
    output logic [23:0]        m_pixel_color,
    output logic signed [15:0] m_pixel_depth,
    output logic               m_last
);
    // controller and datapath talk only through these two bundles
    zbr_cmd_t    cmd;
    zbr_status_t status;

    // the result register sits in the datapath, so a finished pixel waiting
    // on m_ready does not keep the controller from taking the next transfer
    zbr_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_func (s_func),
        .status (status),
        .cmd    (cmd)
    );

    zbr_datapath #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .s_ax         (s_ax),
        .s_ay         (s_ay),
        .s_az         (s_az),
        .s_bx         (s_bx),
        .s_by         (s_by),
        .s_bz         (s_bz),
        .s_cx         (s_cx),
        .s_cy         (s_cy),
        .s_cz         (s_cz),
        .s_color      (s_color),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_pixel_x    (m_pixel_x),
        .m_pixel_y    (m_pixel_y),
        .m_written    (m_written),
        .m_pixel_color(m_pixel_color),
        .m_pixel_depth(m_pixel_depth),
        .m_last       (m_last)
    );
endmodule

// ----- dv/zbr_pixel_checker.sv -----
// Pixel checker: watches both channels, predicts each step result and compares it.
module zbr_pixel_checker
    import zbr_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 256,
    parameter int SCREEN_HEIGHT = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_func,
    input  logic signed [11:0] s_ax,
    input  logic signed [11:0] s_ay,
    input  logic signed [15:0] s_az,
    input  logic signed [11:0] s_bx,
    input  logic signed [11:0] s_by,
    input  logic signed [15:0] s_bz,
    input  logic signed [11:0] s_cx,
    input  logic signed [11:0] s_cy,
    input  logic signed [15:0] s_cz,
    input  logic [23:0]        s_color,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [7:0]         m_pixel_x,
    input  logic [7:0]         m_pixel_y,
    input  logic               m_written,
    input  logic [23:0]        m_pixel_color,
    input  logic signed [15:0] m_pixel_depth,
    input  logic               m_last,
    output int                 mismatches,
    output int                 pixels_pending,
    output int                 pixels_seen,
    output int                 pixels_written
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]         x;
        logic [7:0]         y;
        logic               wr;
        logic [23:0]        col;
        logic signed [15:0] dep;
        logic               last;
    } pixel_result_t;

    pixel_result_t expected_pixels[$];

    // shadow of the block's state
    logic signed [15:0] zbuf[SCREEN_WIDTH*SCREEN_HEIGHT];
    longint vx[3], vy[3], vz[3];
    logic [23:0] tri_col;
    longint xmin, xmax, ymin, ymax, sx, sy, area;
    bit scanning;

    function automatic longint clamp_box(longint v, longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic raster_transfer();
        pixel_result_t r;
        longint ux, uy, uz, dep;
        bit cov;
        int idx;
        if (s_func == FUNC_LOAD) begin
            vx[0] = s_ax; vy[0] = s_ay; vz[0] = s_az;
            vx[1] = s_bx; vy[1] = s_by; vz[1] = s_bz;
            vx[2] = s_cx; vy[2] = s_cy; vz[2] = s_cz;
            tri_col = s_color;
            xmin = vx[0]; xmax = vx[0]; ymin = vy[0]; ymax = vy[0];
            for (int i = 1; i < 3; i++) begin
                if (vx[i] < xmin) xmin = vx[i];
                if (vx[i] > xmax) xmax = vx[i];
                if (vy[i] < ymin) ymin = vy[i];
                if (vy[i] > ymax) ymax = vy[i];
            end
            xmin = clamp_box(xmin, SCREEN_WIDTH - 1);
            xmax = clamp_box(xmax, SCREEN_WIDTH - 1);
            ymin = clamp_box(ymin, SCREEN_HEIGHT - 1);
            ymax = clamp_box(ymax, SCREEN_HEIGHT - 1);
            area = (vx[2] - vx[0]) * (vy[1] - vy[0]) - (vx[1] - vx[0]) * (vy[2] - vy[0]);
            sx = xmin;
            sy = ymin;
            scanning = 1;
            return;
        end
        if (!scanning) return;
        ux = (vx[1] - vx[0]) * (vy[0] - sy) - (vx[0] - sx) * (vy[1] - vy[0]);
        uy = (vx[0] - sx) * (vy[2] - vy[0]) - (vx[2] - vx[0]) * (vy[0] - sy);
        uz = area;
        cov = 0;
        dep = 0;
        if (uz != 0) begin
            if (uz < 0) begin
                ux = -ux; uy = -uy; uz = -uz;
            end
            if (ux >= 0 && uy >= 0 && ux + uy <= uz) begin
                cov = 1;
                dep = (vz[0] * (uz - ux - uy) + vz[1] * uy + vz[2] * ux) / uz;
            end
        end
        r.x = sx[7:0];
        r.y = sy[7:0];
        r.wr = 0;
        idx = int'(sy) * SCREEN_WIDTH + int'(sx);
        if (cov && dep > longint'(zbuf[idx])) begin
            zbuf[idx] = dep[15:0];
            r.wr = 1;
        end
        r.col = r.wr ? tri_col : 24'd0;
        r.dep = cov ? dep[15:0] : 16'sd0;
        r.last = 0;
        if (sy >= ymax) begin
            sy = ymin;
            if (sx >= xmax) begin
                r.last = 1;
                scanning = 0;
            end else begin
                sx++;
            end
        end else begin
            sy++;
        end
        expected_pixels.push_back(r);
    endtask

    initial begin
        mismatches = 0;
        pixels_pending = 0;
        pixels_seen = 0;
        pixels_written = 0;
        foreach (zbuf[i]) zbuf[i] = DEPTH_MIN;
        for (int i = 0; i < 3; i++) begin
            vx[i] = 0; vy[i] = 0; vz[i] = 0;
        end
        tri_col = '0;
        xmin = 0; xmax = 0; ymin = 0; ymax = 0; sx = 0; sy = 0; area = 0;
        scanning = 0;
    end

    always @(posedge aclk) begin
        pixel_result_t e;
        if (aresetn) begin
            if (s_valid && s_ready) raster_transfer();
            if (m_valid && m_ready) begin
                pixels_seen++;
                if (m_written) pixels_written++;
                if (expected_pixels.size() == 0) begin
                    $error("unexpected pixel at x=%0d y=%0d", m_pixel_x, m_pixel_y);
                    mismatches++;
                end else begin
                    e = expected_pixels.pop_front();
                    if (m_pixel_x !== e.x) begin
                        $error("pixel_x expected %0d actual %0d", e.x, m_pixel_x);
                        mismatches++;
                    end
                    if (m_pixel_y !== e.y) begin
                        $error("pixel_y expected %0d actual %0d", e.y, m_pixel_y);
                        mismatches++;
                    end
                    if (m_written !== e.wr) begin
                        $error("written expected %0d actual %0d", e.wr, m_written);
                        mismatches++;
                    end
                    if (m_pixel_color !== e.col) begin
                        $error("pixel_color expected %h actual %h", e.col, m_pixel_color);
                        mismatches++;
                    end
                    if (m_pixel_depth !== e.dep) begin
                        $error("pixel_depth expected %0d actual %0d", e.dep, m_pixel_depth);
                        mismatches++;
                    end
                    if (m_last !== e.last) begin
                        $error("last expected %0d actual %0d", e.last, m_last);
                        mismatches++;
                    end
                end
            end
            pixels_pending = expected_pixels.size();
        end
    end

endmodule

// ----- dv/zbuffered_triangle_raster_tb.sv -----
// Testbench top: drives triangle loads and pixel steps, gives the verdict.
module zbuffered_triangle_raster_tb;
    import zbr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // cycles with no transfer on either channel before the run is declared hung;
    // covers the depth clear after reset plus long receiver stalls
    localparam int STALL_LIMIT = 300000;
    localparam int RANDOM_ITEMS = 1900;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic               s_func = FUNC_STEP;
    logic signed [11:0] s_ax = 0, s_ay = 0, s_bx = 0, s_by = 0, s_cx = 0, s_cy = 0;
    logic signed [15:0] s_az = 0, s_bz = 0, s_cz = 0;
    logic [23:0]        s_color = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [7:0]         m_pixel_x, m_pixel_y;
    logic               m_written, m_last;
    logic [23:0]        m_pixel_color;
    logic signed [15:0] m_pixel_depth;

    int mismatches, pixels_pending, pixels_seen, pixels_written;
    int send_idle_pct, recv_idle_pct;
    int items_sent, loads_sent;
    int quiet_cycles;

    zbuffered_triangle_raster u_dut (.*);

    zbr_pixel_checker u_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_func,
        .s_ax, .s_ay, .s_az, .s_bx, .s_by, .s_bz, .s_cx, .s_cy, .s_cz, .s_color,
        .m_valid, .m_ready, .m_pixel_x, .m_pixel_y, .m_written,
        .m_pixel_color, .m_pixel_depth, .m_last,
        .mismatches, .pixels_pending, .pixels_seen, .pixels_written
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // receiver back-pressure, redrawn every falling edge
    always @(negedge aclk) m_ready <= ($urandom_range(99) >= recv_idle_pct);

    // watchdog: any transfer on either channel resets the count
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one transfer; called at a falling edge, returns at a falling edge
    // with valid dropped. Payload bits not used by a step are still random.
    task automatic send_item(input logic f,
                             input int ax, input int ay, input int az,
                             input int bx, input int by, input int bz,
                             input int cx, input int cy, input int cz,
                             input logic [23:0] col);
        while ($urandom_range(99) < send_idle_pct) @(negedge aclk);
        s_func = f;
        s_ax = 12'(ax); s_ay = 12'(ay); s_az = 16'(az);
        s_bx = 12'(bx); s_by = 12'(by); s_bz = 16'(bz);
        s_cx = 12'(cx); s_cy = 12'(cy); s_cz = 16'(cz);
        s_color = col;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        s_valid = 1'b0;
        items_sent++;
        if (f == FUNC_LOAD) loads_sent++;
    endtask

    task automatic step_pixel();
        send_item(FUNC_STEP, $urandom, $urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom, 24'($urandom));
    endtask

    task automatic load_tri(input int ax, input int ay, input int az,
                            input int bx, input int by, input int bz,
                            input int cx, input int cy, input int cz,
                            input logic [23:0] col);
        send_item(FUNC_LOAD, ax, ay, az, bx, by, bz, cx, cy, cz, col);
    endtask

    function automatic int box_span(input int a, input int b, input int c);
        int lo, hi;
        lo = a < b ? a : b;
        lo = lo < c ? lo : c;
        hi = a > b ? a : b;
        hi = hi > c ? hi : c;
        lo = lo < 0 ? 0 : (lo > 255 ? 255 : lo);
        hi = hi < 0 ? 0 : (hi > 255 ? 255 : hi);
        return hi - lo + 1;
    endfunction

    // One random sequence: a load followed by steps. Mostly small triangles
    // crowded into one corner so the depth test sees overlapping pixels;
    // the rest are degenerate, full-range noise, or aborted scans.
    task automatic random_sequence();
        int kind, x0, y0, ax, ay, bx, by, cx, cy, pixels, steps;
        kind = $urandom_range(99);
        x0 = $urandom_range(22) - 3;
        y0 = $urandom_range(22) - 3;
        ax = x0 + $urandom_range(6); ay = y0 + $urandom_range(6);
        bx = x0 + $urandom_range(6); by = y0 + $urandom_range(6);
        cx = x0 + $urandom_range(6); cy = y0 + $urandom_range(6);
        if (kind < 10) begin
            // collinear: third vertex on the line through the first two
            cx = 2 * bx - ax;
            cy = 2 * by - ay;
        end
        if (kind >= 88) begin
            // full-range noise load; huge box, so only a few steps
            load_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, 24'($urandom));
            steps = $urandom_range(4);
        end else begin
            load_tri(ax, ay, $urandom_range(65535) - 32768,
                     bx, by, $urandom_range(65535) - 32768,
                     cx, cy, $urandom_range(65535) - 32768, 24'($urandom));
            pixels = box_span(ax, bx, cx) * box_span(ay, by, cy);
            if (kind < 80) steps = pixels + $urandom_range(2);
            else steps = $urandom_range(pixels);  // aborted by the next load
        end
        for (int i = 0; i < steps; i++) step_pixel();
    endtask

    initial begin
        send_idle_pct = 8;
        recv_idle_pct = 71;
        items_sent = 0;
        loads_sent = 0;
        quiet_cycles = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed part
        step_pixel();                                           // step while idle
        load_tri(0, 0, 16384, 2, 0, 0, 0, 2, -16384, 24'hFFFFFF);
        repeat (10) step_pixel();                               // whole box, then idle
        load_tri(0, 0, -32768, 2, 0, -32768, 0, 2, -32768, 24'h000000); // never passes
        repeat (2) step_pixel();
        load_tri(0, 0, 100, 1, 1, 200, 2, 2, 300, 24'h123456);  // degenerate
        repeat (2) step_pixel();
        load_tri(-2048, -2048, 32767, -2040, -2048, 32767, -2048, -2040, 32767,
                 24'hABCDEF);                                   // off screen, aborts scan
        step_pixel();
        load_tri(2047, 2047, 32767, 2047, -2048, -32768, -2048, 2047, 0, 24'hFFFFFF);
        repeat (3) step_pixel();

        // pause until the block has drained
        while (pixels_pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);

        while (items_sent < RANDOM_ITEMS + 25) begin
            if (items_sent > 25 + 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (items_sent > 25 + RANDOM_ITEMS / 3) begin
                send_idle_pct = 71;
                recv_idle_pct = 8;
            end
            random_sequence();
        end

        while (pixels_pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);

        $display("covered %0d transfers (%0d loads), %0d pixels checked, %0d written",
                 items_sent, loads_sent, pixels_seen, pixels_written);
        if (mismatches == 0 && pixels_pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/zbr_pkg.sv
rtl/zbr_ram.sv
rtl/zbr_ctrl.sv
rtl/zbr_datapath.sv
rtl/zbuffered_triangle_raster.sv
dv/zbr_pixel_checker.sv
dv/zbuffered_triangle_raster_tb.sv
